[hw/rtl/dse_pkg.sv]
package dse_pkg;

    // Register file geometry; the instruction format fixes it at 32 registers.
    localparam int REG_COUNT     = 32;
    localparam int REG_ADDR_BITS = 5;
    localparam int DATA_BITS     = 32;
    localparam int IMM_BITS      = 16;
    localparam int PC_BITS_DEF   = 16;

    typedef logic [5:0] opcode_t;
    typedef logic [5:0] funct_t;
    typedef logic [REG_ADDR_BITS-1:0] reg_addr_t;
    typedef logic [DATA_BITS-1:0] word_t;

    localparam opcode_t OP_RTYPE = 6'h00;
    localparam opcode_t OP_J     = 6'h02;
    localparam opcode_t OP_ANDI  = 6'h0c;
    localparam opcode_t OP_ORI   = 6'h0d;
    localparam opcode_t OP_XORI  = 6'h0e;
    localparam opcode_t OP_LHI   = 6'h0f;
    localparam opcode_t OP_JR    = 6'h12;

    localparam funct_t FN_NOP = 6'h00;
    localparam funct_t FN_SLL = 6'h04;
    localparam funct_t FN_SRL = 6'h06;
    localparam funct_t FN_SRA = 6'h07;
    localparam funct_t FN_ADD = 6'h20;
    localparam funct_t FN_SUB = 6'h22;

    // Register write and status produced by the execute stage.
    typedef struct packed {
        logic      wr_en;
        reg_addr_t wr_addr;
        word_t     wr_value;
        logic      unknown;
    } exec_result_t;

endpackage

[hw/rtl/dse_regfile.sv]
module dse_regfile (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  dse_pkg::reg_addr_t   rd_addr_a,
    input  dse_pkg::reg_addr_t   rd_addr_b,
    output dse_pkg::word_t       rd_data_a,
    output dse_pkg::word_t       rd_data_b,
    input  logic                 wr_en,
    input  dse_pkg::reg_addr_t   wr_addr,
    input  dse_pkg::word_t       wr_data
);
    import dse_pkg::*;

    word_t                mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    word_t                rd_data_a_reg;
    word_t                rd_data_b_reg;

    // Entries never written since reset read as zero. R0 is never written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read with write-first bypass for a write on the same edge.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr_a))
            begin
                rd_data_a_reg <= wr_data;
            end
            else
            begin
                rd_data_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
            end
            if (wr_en && (wr_addr == rd_addr_b))
            begin
                rd_data_b_reg <= wr_data;
            end
            else
            begin
                rd_data_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
            end
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

[hw/rtl/dse_exec.sv]
module dse_exec #(
    parameter int PC_BITS = dse_pkg::PC_BITS_DEF
) (
    input  dse_pkg::word_t         instr,
    input  dse_pkg::word_t         op_a,
    input  dse_pkg::word_t         op_b,
    input  logic [PC_BITS-1:0]     pc,
    output logic [PC_BITS-1:0]     pc_next,
    output dse_pkg::exec_result_t  result
);
    import dse_pkg::*;

    opcode_t               opcode;
    funct_t                funct;
    reg_addr_t             dest;
    logic [IMM_BITS-1:0]   imm;
    word_t                 imm_ext;
    logic [4:0]            shamt;
    word_t                 value;
    logic                  writes;
    logic                  unknown;
    logic [PC_BITS+IMM_BITS-1:0]  jump_sum;
    logic [PC_BITS+DATA_BITS-1:0] jr_wide;
    logic [PC_BITS-1:0]    pc_inc;

    assign opcode  = instr[31:26];
    assign funct   = instr[5:0];
    assign imm     = instr[15:0];
    assign imm_ext = {{(DATA_BITS-IMM_BITS){1'b0}}, imm};
    assign shamt   = op_b[4:0];
    assign dest    = (opcode == OP_RTYPE) ? instr[15:11] : instr[20:16];

    assign pc_inc   = pc + {{(PC_BITS-1){1'b0}}, 1'b1};
    assign jump_sum = {{IMM_BITS{1'b0}}, pc} + {{PC_BITS{1'b0}}, imm};
    assign jr_wide  = {{PC_BITS{1'b0}}, op_a};

    always_comb
    begin
        value   = '0;
        writes  = 1'b0;
        unknown = 1'b0;
        pc_next = pc_inc;
        unique case (opcode)
            OP_RTYPE:
            begin
                unique case (funct)
                    FN_NOP:
                    begin
                        unknown = (instr != '0);
                    end
                    FN_SLL:
                    begin
                        value  = op_a << shamt;
                        writes = 1'b1;
                    end
                    FN_SRL:
                    begin
                        value  = op_a >> shamt;
                        writes = 1'b1;
                    end
                    FN_SRA:
                    begin
                        value  = word_t'($signed(op_a) >>> shamt);
                        writes = 1'b1;
                    end
                    FN_ADD:
                    begin
                        value  = op_a + op_b;
                        writes = 1'b1;
                    end
                    FN_SUB:
                    begin
                        value  = op_a - op_b;
                        writes = 1'b1;
                    end
                    default:
                    begin
                        unknown = 1'b1;
                    end
                endcase
            end
            OP_J:
            begin
                pc_next = jump_sum[PC_BITS-1:0];
            end
            OP_ANDI:
            begin
                value  = op_a & imm_ext;
                writes = 1'b1;
            end
            OP_ORI:
            begin
                value  = op_a | imm_ext;
                writes = 1'b1;
            end
            OP_XORI:
            begin
                value  = op_a ^ imm_ext;
                writes = 1'b1;
            end
            OP_LHI:
            begin
                value  = {imm, {(DATA_BITS-IMM_BITS){1'b0}}};
                writes = 1'b1;
            end
            OP_JR:
            begin
                pc_next = jr_wide[PC_BITS-1:0];
            end
            default:
            begin
                unknown = 1'b1;
            end
        endcase
    end

    // A write to R0 is dropped and reported as no write at all.
    always_comb
    begin
        result.unknown = unknown;
        if (writes && (dest != '0))
        begin
            result.wr_en    = 1'b1;
            result.wr_addr  = dest;
            result.wr_value = value;
        end
        else
        begin
            result.wr_en    = 1'b0;
            result.wr_addr  = '0;
            result.wr_value = '0;
        end
    end

endmodule

[hw/rtl/dlx_subset_execute.sv]
// Executes a subset of DLX integer instructions (sll, srl, sra, add, sub,
// andi, ori, xori, lhi, j, jr) at one instruction per clock cycle unless
// m_tready stalls the output. Each input beat carries one instruction word in
// s_tdata and a clear-marks flag in s_tuser; each output beat reports the next
// program counter, the register write, the written marks after the instruction
// and an unknown-opcode flag. The register file is a synchronous memory with
// one write and two read ports: operands are read on the edge that accepts the
// beat, and the execute stage computes the result from them and, when it
// advances, writes the register file and loads the output register. A write on
// the same edge as a read is bypassed into the read data, so back-to-back
// dependent instructions need no stall. A beat passes the operand registers,
// then the output register; with m_tready held high the block sustains one
// beat per cycle. R0 always reads as zero; all registers do so after reset.
module dlx_subset_execute #(
    parameter int PC_BITS = dse_pkg::PC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instruction_word
    input  logic [0:0]  s_tuser,   // [0] clear_marks

    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] next_pc, [16] write_enable, [21:17] write_register,
    // [53:22] write_value, [85:54] written_mask, [86] unknown_opcode, [87] zero
    output logic [87:0] m_tdata
);
    import dse_pkg::*;

    logic                   s_accept;
    logic                   ex_adv;
    logic                   ex_valid_reg;
    word_t                  ex_instr_reg;
    logic                   ex_clear_reg;
    word_t                  op_a;
    word_t                  op_b;
    logic [PC_BITS-1:0]     pc_reg;
    logic [PC_BITS-1:0]     pc_next;
    logic [REG_COUNT-1:0]   marks_reg;
    logic [REG_COUNT-1:0]   marks_next;
    exec_result_t           ex_result;
    logic                   out_valid_reg;
    logic [87:0]            out_data_reg;
    logic [PC_BITS+15:0]    pc_wide;

    // The execute stage moves on when the output register is free or drains.
    assign ex_adv   = ex_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !ex_valid_reg || ex_adv;
    assign s_accept = s_tvalid && s_tready;

    dse_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (s_accept),
        .rd_addr_a (s_tdata[25:21]),
        .rd_addr_b (s_tdata[20:16]),
        .rd_data_a (op_a),
        .rd_data_b (op_b),
        .wr_en     (ex_adv && ex_result.wr_en),
        .wr_addr   (ex_result.wr_addr),
        .wr_data   (ex_result.wr_value)
    );

    dse_exec #(
        .PC_BITS (PC_BITS)
    ) u_exec (
        .instr   (ex_instr_reg),
        .op_a    (op_a),
        .op_b    (op_b),
        .pc      (pc_reg),
        .pc_next (pc_next),
        .result  (ex_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            ex_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ex_instr_reg <= s_tdata;
            ex_clear_reg <= s_tuser[0];
        end
    end

    // Marks are cleared first when asked, then the destination bit is set.
    always_comb
    begin
        marks_next = ex_clear_reg ? '0 : marks_reg;
        if (ex_result.wr_en)
        begin
            marks_next[ex_result.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            marks_reg <= '0;
        end
        else if (ex_adv)
        begin
            pc_reg    <= pc_next;
            marks_reg <= marks_next;
        end
    end

    assign pc_wide = {16'b0, pc_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ex_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_adv)
        begin
            out_data_reg <= {1'b0,
                             ex_result.unknown,
                             marks_next,
                             ex_result.wr_value,
                             ex_result.wr_addr,
                             ex_result.wr_en,
                             pc_wide[15:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
